// ----- rtl/csvt_pkg.sv -----
// Shared types and constants for the CSV field tokenizer.
// No dependencies; used by csvt_core and csv_field_tokenizer.
package csvt_pkg;

  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;

  localparam logic [7:0] QUOTE_BYTE    = 8'h22;
  localparam logic [7:0] CR_BYTE       = 8'h0D;
  localparam logic [7:0] LF_BYTE       = 8'h0A;
  localparam logic [7:0] DEFAULT_DELIM = 8'h2C;

  typedef struct packed {
    logic       has_token;
    logic [1:0] kind;
    logic [7:0] ch;
  } token_t;

endpackage

// ----- rtl/csv_field_tokenizer.sv -----
// Streaming CSV tokenizer top level: config register, decode core, output skid.
// Depends on csvt_pkg and csvt_core.
//
// Input channel: in_valid/in_stall carry data_byte and end_of_text. One byte is
// taken per transaction; end_of_text flushes a final row end if the row holds
// anything and returns the quote state to start.
// Output channel: out_valid/out_stall carry token_kind (0 character, 1 field
// end, 2 row end) and char_value (zero unless token_kind is 0).
// Each transaction yields zero or one token, registered into the output or
// skid register. Throughput is one byte per cycle while in_stall is low, set
// by the combinational decode of the three quote/row state bits.
// A one-entry skid register sits behind the output register; in_stall rises
// only once both are full, so the input keeps flowing through an output stall
// until the skid register fills.
// Configuration: cfg_wr_en/cfg_wr_data write delimiter_char; write only while
// idle.
// Reset (rst, synchronous): delimiter returns to comma, quote and row state
// clear, output and skid registers empty.
module csv_field_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_kind,
  output logic [7:0] char_value
);

  logic [7:0]       delimiter_char;
  logic             accept;
  logic             out_advance;
  csvt_pkg::token_t token;
  logic             skid_valid;
  logic [1:0]       skid_kind;
  logic [7:0]       skid_char;

  assign in_stall    = skid_valid;
  assign accept      = in_valid && !skid_valid;
  assign out_advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= csvt_pkg::DEFAULT_DELIM;
    end else if (cfg_wr_en) begin
      delimiter_char <= cfg_wr_data;
    end
  end

  csvt_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .data_byte      (data_byte),
    .end_of_text    (end_of_text),
    .delimiter_char (delimiter_char),
    .token          (token)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_advance) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        token_kind <= skid_kind;
        char_value <= skid_char;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept && token.has_token;
        token_kind <= token.kind;
        char_value <= token.ch;
      end
    end else if (accept && token.has_token) begin
      skid_valid <= 1'b1;
      skid_kind  <= token.kind;
      skid_char  <= token.ch;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind != csvt_pkg::KIND_CHAR) |-> char_value == 8'd0)
    else $error("nonzero char_value on a field or row end");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_kind == csvt_pkg::KIND_CHAR ||
                   token_kind == csvt_pkg::KIND_FIELD_END ||
                   token_kind == csvt_pkg::KIND_ROW_END))
    else $error("illegal token_kind");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid))
    else $error("output not empty after reset");
`endif

endmodule

// ----- rtl/csvt_core.sv -----
// Tokenizer state (quote mode, pending quote, row started) and per-byte decode.
// Depends on csvt_pkg. Produces at most one token per accepted transaction.
module csvt_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_text,
  input  logic [7:0]        delimiter_char,
  output csvt_pkg::token_t  token
);

  logic inside_quotes, quote_pending, row_started;
  logic inside_quotes_next, quote_pending_next, row_started_next;

  always_comb begin
    inside_quotes_next = inside_quotes;
    quote_pending_next = quote_pending;
    row_started_next   = row_started;
    token.has_token    = 1'b0;
    token.kind         = csvt_pkg::KIND_CHAR;
    token.ch           = 8'd0;
    if (end_of_text) begin
      inside_quotes_next = 1'b0;
      quote_pending_next = 1'b0;
      row_started_next   = 1'b0;
      if (row_started) begin
        token.has_token = 1'b1;
        token.kind      = csvt_pkg::KIND_ROW_END;
      end
    end else if (quote_pending && data_byte == csvt_pkg::QUOTE_BYTE) begin
      quote_pending_next = 1'b0;
      row_started_next   = 1'b1;
      token.has_token    = 1'b1;
      token.ch           = csvt_pkg::QUOTE_BYTE;
    end else if (inside_quotes && !quote_pending) begin
      if (data_byte == csvt_pkg::QUOTE_BYTE) begin
        quote_pending_next = 1'b1;
      end else begin
        row_started_next = 1'b1;
        token.has_token  = 1'b1;
        token.ch         = data_byte;
      end
    end else begin
      // unquoted handling, also after a closing quote
      quote_pending_next = 1'b0;
      inside_quotes_next = 1'b0;
      if (data_byte == csvt_pkg::QUOTE_BYTE) begin
        inside_quotes_next = 1'b1;
        row_started_next   = 1'b1;
      end else if (data_byte == delimiter_char) begin
        row_started_next = 1'b1;
        token.has_token  = 1'b1;
        token.kind       = csvt_pkg::KIND_FIELD_END;
      end else if (data_byte == csvt_pkg::CR_BYTE) begin
        token.has_token = 1'b0;
      end else if (data_byte == csvt_pkg::LF_BYTE) begin
        row_started_next = 1'b0;
        token.has_token  = 1'b1;
        token.kind       = csvt_pkg::KIND_ROW_END;
      end else begin
        row_started_next = 1'b1;
        token.has_token  = 1'b1;
        token.ch         = data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes <= 1'b0;
      quote_pending <= 1'b0;
      row_started   <= 1'b0;
    end else if (step) begin
      inside_quotes <= inside_quotes_next;
      quote_pending <= quote_pending_next;
      row_started   <= row_started_next;
    end
  end

endmodule
